@@ hw/rtl/fx16d_pkg.sv @@
// Shared types and constants for the fixed-point divider pipeline.
package fx16d_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned QUO_W  = 30;

    localparam logic [WORD_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
        logic [WORD_W-1:0] mb;
        logic              neg;
        logic              sat;
    } stage_t;

endpackage

@@ hw/rtl/fx16d_prep.sv @@
// Input stage: operand magnitudes, sign, overflow guard and initial remainder.
module fx16d_prep #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [fx16d_pkg::WORD_W-1:0] dividend,
    input  logic signed [fx16d_pkg::WORD_W-1:0] divisor,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fx16d_pkg::stage_t                 out_data
);

    localparam int unsigned GUARD_SHIFT = 30 - FRAC_BITS;

    logic [fx16d_pkg::WORD_W-1:0] ma;
    logic [fx16d_pkg::WORD_W-1:0] mb;
    logic [fx16d_pkg::WORD_W-1:0] ma_shr;
    logic                         valid_reg;
    fx16d_pkg::stage_t            data_reg;
    fx16d_pkg::stage_t            data_next;

    assign ma     = dividend[fx16d_pkg::WORD_W-1] ? (~dividend + 1'b1) : dividend;
    assign mb     = divisor[fx16d_pkg::WORD_W-1]  ? (~divisor + 1'b1)  : divisor;
    assign ma_shr = ma >> GUARD_SHIFT;

    always_comb begin
        data_next.rem = ma_shr;
        data_next.num = fx16d_pkg::QUO_W'(ma << FRAC_BITS);
        data_next.quo = '0;
        data_next.mb  = mb;
        data_next.neg = dividend[fx16d_pkg::WORD_W-1] ^ divisor[fx16d_pkg::WORD_W-1];
        data_next.sat = (ma_shr >= mb);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/fx16d_step.sv @@
// One restoring-division step: shift in a numerator bit, trial subtract, record a quotient bit.
module fx16d_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fx16d_pkg::stage_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fx16d_pkg::stage_t out_data
);

    logic [fx16d_pkg::WORD_W:0] partial;
    logic [fx16d_pkg::WORD_W:0] trial;
    logic                       fits;
    logic                       valid_reg;
    fx16d_pkg::stage_t          data_reg;
    fx16d_pkg::stage_t          data_next;

    assign partial = {in_data.rem, in_data.num[fx16d_pkg::QUO_W-1]};
    assign trial   = partial - {1'b0, in_data.mb};
    assign fits    = !trial[fx16d_pkg::WORD_W];

    always_comb begin
        data_next     = in_data;
        data_next.rem = fits ? trial[fx16d_pkg::WORD_W-1:0] : partial[fx16d_pkg::WORD_W-1:0];
        data_next.num = {in_data.num[fx16d_pkg::QUO_W-2:0], 1'b0};
        data_next.quo = {in_data.quo[fx16d_pkg::QUO_W-2:0], fits};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/fx16d_post.sv @@
// Output stage: apply sign or saturate, and hold the result for the master side.
module fx16d_post (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fx16d_pkg::stage_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fx16d_pkg::WORD_W-1:0] quotient,
    output logic                              saturated
);

    logic [fx16d_pkg::WORD_W-1:0] mag;
    logic [fx16d_pkg::WORD_W-1:0] quo_next;
    logic [fx16d_pkg::WORD_W-1:0] quo_reg;
    logic                         sat_reg;
    logic                         valid_reg;

    assign mag = {2'b00, in_data.quo};

    always_comb begin
        if (in_data.sat) begin
            quo_next = in_data.neg ? fx16d_pkg::MOST_NEG : fx16d_pkg::MOST_POS;
        end else if (in_data.neg) begin
            quo_next = ~mag + 1'b1;
        end else begin
            quo_next = mag;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            quo_reg <= quo_next;
            sat_reg <= in_data.sat;
        end
    end

    assign out_valid = valid_reg;
    assign quotient  = quo_reg;
    assign saturated = sat_reg;

endmodule

@@ hw/rtl/fixed_16_16_saturating_divider_core.sv @@
// Top level of the pipelined saturating signed fixed-point divider.
//
//  Channel | Direction | Payload
//  s_      | in        | tdata[31:0] dividend, tdata[63:32] divisor
//  m_      | out       | tdata[31:0] quotient, tuser saturated
//
//  Takes one item per cycle unless a stalled output has filled every stage; each item passes 32
//  register stages: one operand stage, one stage per quotient bit (30), and one
//  sign/saturation stage. An item goes from the operand register through the
//  step registers to the output register, from which it can leave.
//  Every stage holds its item while the stage after it is full and stalled.
//  Reset (aresetn low at a clock edge) empties every stage.
module fixed_16_16_saturating_divider_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] dividend, [63:32] divisor
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] quotient
    output logic        m_tuser   // [0] saturated
);

    localparam int unsigned STEPS = fx16d_pkg::QUO_W;

    logic              valid_chain [STEPS+1];
    logic              ready_chain [STEPS+1];
    fx16d_pkg::stage_t data_chain  [STEPS+1];

    fx16d_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dividend  (s_tdata[31:0]),
        .divisor   (s_tdata[63:32]),
        .out_valid (valid_chain[0]),
        .out_ready (ready_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        fx16d_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    fx16d_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_chain[STEPS]),
        .in_ready  (ready_chain[STEPS]),
        .in_data   (data_chain[STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .quotient  (m_tdata),
        .saturated (m_tuser)
    );

`ifndef SYNTHESIS
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata == fx16d_pkg::MOST_NEG || m_tdata == fx16d_pkg::MOST_POS))
        else $error("saturated item without extreme quotient");

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[31] == m_tdata[30]))
        else $error("unsaturated quotient outside 30-bit magnitude");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled output item");
`endif

endmodule

@@ tb/fixed_16_16_saturating_divider_core_tb.sv @@
// Self-checking testbench for the pipelined saturating signed 16.16 divider.
module fixed_16_16_saturating_divider_core_tb;

    localparam int FRAC_BITS   = 16;
    localparam int GUARD_SHIFT = 30 - FRAC_BITS;
    localparam int RAND_ITEMS  = 1700;
    localparam int LONG_HOLD   = 120;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        logic [31:0] quotient;
        logic        saturated;
    } quo_res_t;

    typedef struct packed {
        logic [31:0] dividend;
        logic [31:0] divisor;
        quo_res_t    res;
    } div_job_t;

    typedef struct packed {
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic        typed;
        logic [31:0] quotient;
        logic        saturated;
    } div_case_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;  // [31:0] dividend, [63:32] divisor
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;         // [31:0] quotient
    logic        m_tuser;         // [0] saturated

    div_job_t    quo_q[$];
    div_job_t    pending_job;
    int          errors    = 0;
    int          cycles    = 0;
    bit          calm      = 1'b0;
    bit          hold_out  = 1'b0;

    fixed_16_16_saturating_divider_core #(.FRAC_BITS(FRAC_BITS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    div_case_t directed_cases [N_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, fx16d_pkg::MOST_POS, 1'b1},
        '{32'h0001_0000, 32'h0000_0000, 1'b1, fx16d_pkg::MOST_POS, 1'b1},
        '{32'hFFFF_0000, 32'h0000_0000, 1'b1, fx16d_pkg::MOST_NEG, 1'b1},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0001_0000,       1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0001_0000,       1'b0},
        '{32'h8000_0000, 32'h0000_0001, 1'b1, fx16d_pkg::MOST_NEG, 1'b1},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, fx16d_pkg::MOST_NEG, 1'b1},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, fx16d_pkg::MOST_POS, 1'b1},
        '{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000,       1'b0},
        '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000,       1'b0},
        '{32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0000_8000,       1'b0},
        '{32'hFFFF_0000, 32'h0002_0000, 1'b1, 32'hFFFF_8000,       1'b0},
        '{32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000,       1'b0},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000,       1'b0},
        '{32'h4000_0000, 32'h0001_0000, 1'b1, fx16d_pkg::MOST_POS, 1'b1},
        '{32'h3FFF_FFFF, 32'h0001_0000, 1'b1, 32'h3FFF_FFFF,       1'b0},
        '{32'hC000_0001, 32'h0001_0000, 1'b1, 32'hC000_0001,       1'b0},
        '{32'h0000_4000, 32'h0000_0001, 1'b1, fx16d_pkg::MOST_POS, 1'b1},
        '{32'h0000_3FFF, 32'h0000_0001, 1'b1, 32'h3FFF_0000,       1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000,       1'b0},
        '{32'h0003_0000, 32'h0001_0000, 1'b1, 32'h0003_0000,       1'b0},
        '{32'h0001_0000, 32'h0003_0000, 1'b0, 32'h0000_0000,       1'b0},
        '{32'h8000_0000, 32'hFFFE_0000, 1'b1, fx16d_pkg::MOST_POS, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0001_0000,       1'b0}
    };

    function automatic quo_res_t predict_quotient(logic [31:0] dividend, logic [31:0] divisor);
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] q;
        logic        neg;
        quo_res_t    r;
        mag_a = dividend[31] ? {32'd0, ~dividend} + 64'd1 : {32'd0, dividend};
        mag_b = divisor[31]  ? {32'd0, ~divisor}  + 64'd1 : {32'd0, divisor};
        neg   = dividend[31] ^ divisor[31];
        if ((mag_a >> GUARD_SHIFT) >= mag_b) begin
            r.quotient  = neg ? fx16d_pkg::MOST_NEG : fx16d_pkg::MOST_POS;
            r.saturated = 1'b1;
        end else begin
            q           = (mag_a << FRAC_BITS) / mag_b;
            r.quotient  = neg ? (~q[31:0] + 32'd1) : q[31:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[fixed_16_16_saturating_divider_core] ERROR");
            $finish;
        end
    end

    // Record accepted items and check results against the oldest expectation.
    always @(posedge aclk) begin : result_check
        div_job_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                quo_q.push_back(pending_job);
            if (m_tvalid && m_tready) begin
                if (quo_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: quotient=%h saturated=%b", m_tdata, m_tuser);
                end else begin
                    want = quo_q.pop_front();
                    if (m_tdata !== want.res.quotient || m_tuser !== want.res.saturated) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch %h / %h: expected %h sat %b, got %h sat %b",
                                     want.dividend, want.divisor, want.res.quotient,
                                     want.res.saturated, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold, none while calm.
    initial begin : result_sink
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_out) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_out = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer_item(input logic [31:0] dividend, input logic [31:0] divisor,
                              input quo_res_t want);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid    <= 1'b1;
        s_tdata     <= {divisor, dividend};
        pending_job  = '{dividend, divisor, want};
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin : stimulus
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] mag;
        int          mode;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[i]) begin
            offer_item(directed_cases[i].dividend, directed_cases[i].divisor,
                       directed_cases[i].typed
                           ? quo_res_t'{directed_cases[i].quotient, directed_cases[i].saturated}
                           : predict_quotient(directed_cases[i].dividend,
                                              directed_cases[i].divisor));
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= 1000 && n < 1150) || (n >= RAND_ITEMS - 200);
            if (n == 400)
                hold_out = 1'b1;
            if (n == 800) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (quo_q.size() == 0);
            end
            mode = $urandom_range(0, 4);
            case (mode)
                0: begin
                    a = $urandom;
                    b = $urandom;
                end
                1: begin
                    // divisor of random magnitude, mostly saturating
                    a = $urandom;
                    b = $urandom >> $urandom_range(0, 31);
                    if ($urandom_range(0, 1)) b = ~b + 32'd1;
                end
                2: begin
                    // small dividend, mostly a real quotient
                    a = $urandom >> $urandom_range(0, 31);
                    b = $urandom >> $urandom_range(0, 16);
                    if ($urandom_range(0, 1)) a = ~a + 32'd1;
                    if ($urandom_range(0, 1)) b = ~b + 32'd1;
                end
                3: begin
                    // straddle the overflow guard
                    b   = $urandom_range(1, 131071);
                    mag = ({32'd0, b} << GUARD_SHIFT) + 64'($urandom_range(0, 2)) - 64'd1;
                    a   = mag[31:0];
                    if ($urandom_range(0, 1)) a = ~a + 32'd1;
                    if ($urandom_range(0, 1)) b = ~b + 32'd1;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: a = 32'h0000_0000;
                        1: a = 32'h0000_0001;
                        2: a = 32'hFFFF_FFFF;
                        3: a = fx16d_pkg::MOST_NEG;
                        4: a = fx16d_pkg::MOST_POS;
                        default: a = $urandom;
                    endcase
                    case ($urandom_range(0, 5))
                        0: b = 32'h0000_0000;
                        1: b = 32'h0000_0001;
                        2: b = 32'hFFFF_FFFF;
                        3: b = fx16d_pkg::MOST_NEG;
                        4: b = fx16d_pkg::MOST_POS;
                        default: b = $urandom;
                    endcase
                end
            endcase
            offer_item(a, b, predict_quotient(a, b));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (quo_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("[fixed_16_16_saturating_divider_core] OK");
        else
            $display("[fixed_16_16_saturating_divider_core] ERROR");
        $finish;
    end

endmodule
